/* hdl/rrbig_pkg.sv */
// Shared types and codes for the round robin batch index generator.
package rrbig_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_SAMPLES    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PARTITION_ID   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_PARTITIONS = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BATCH_SIZE     = 2'd3;

    // Stream layout
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TUSER_BITS = 2;
    localparam int TUSER_VALID    = 0;
    localparam int TUSER_BAD      = 1;

    // Shared arithmetic unit operations
    localparam logic ALU_MUL = 1'b0;
    localparam logic ALU_DIV = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } alu_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_sts_t;

endpackage

/* hdl/rrbig_alu.sv */
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module rrbig_alu #(
    parameter int OPW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rrbig_pkg::alu_ctl_t  ctl,
    input  logic [OPW-1:0]       opa,
    input  logic [OPW-1:0]       opb,
    output rrbig_pkg::alu_sts_t  sts,
    output logic [OPW-1:0]       quo,
    output logic [OPW-1:0]       rem
);
    import rrbig_pkg::*;

    localparam int CW = $clog2(OPW + 1);

    logic [OPW:0]   acc_reg, acc_next;
    logic [OPW:0]   d_reg, d_next;
    logic [OPW-1:0] q_reg, q_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           op_reg, op_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;

    logic [OPW:0]   trial;
    logic [OPW:0]   add_x;
    logic [OPW:0]   add_y;
    logic [OPW+1:0] sum;
    logic           sub;
    logic           carry;

    // Single adder: accumulate for multiply, trial subtract for divide
    always_comb
    begin
        trial = {acc_reg[OPW-1:0], q_reg[OPW-1]};
        sub   = (op_reg == ALU_DIV);
        add_x = sub ? trial : acc_reg;
        add_y = sub ? ~d_reg : d_reg;
        sum   = {1'b0, add_x} + {1'b0, add_y} + (OPW + 2)'(sub);
        carry = sum[OPW+1];
    end

    // Sequence one step per cycle
    always_comb
    begin
        acc_next  = acc_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start && !busy_reg)
        begin
            op_next   = ctl.op;
            acc_next  = '0;
            busy_next = 1'b1;
            cnt_next  = CW'(OPW);
            if (ctl.op == ALU_DIV)
            begin
                q_next = opa;
                d_next = {1'b0, opb};
            end
            else
            begin
                q_next = opb;
                d_next = {1'b0, opa};
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == ALU_DIV)
            begin
                acc_next = carry ? sum[OPW:0] : trial;
                q_next   = {q_reg[OPW-2:0], carry};
            end
            else
            begin
                if (q_reg[0])
                begin
                    acc_next = sum[OPW:0];
                end
                d_next = {d_reg[OPW-1:0], 1'b0};
                q_next = {1'b0, q_reg[OPW-1:1]};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            d_reg    <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            op_reg   <= ALU_MUL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            d_reg    <= d_next;
            q_reg    <= q_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quo      = (op_reg == ALU_DIV) ? q_reg : acc_reg[OPW-1:0];
    assign rem      = acc_reg[OPW-1:0];

endmodule

/* hdl/round_robin_batch_index_generator_core.sv */
// Top level: configuration, walk sequencer and output register.
//
// Each request item returns one result item. A request within the current batch
// passes through accept, check and produce states before its result is written
// to the output register. Every multiply and divide runs on one shared
// bit-serial unit of width OPW = max(INDEX_BITS, 2*PART_BITS). Moving into the
// next full batch costs three such operations after the result is out; the tail
// batch needs none. A restart runs up to five operations for the batch count
// and the tail split, plus the entry into the first batch, before its result.
// The input side is ready only while the sequencer is idle; the result waits
// in an output register, and a stalled consumer holds that register, so the
// next result waits in the produce or check state until it is free.
module round_robin_batch_index_generator_core #(
    parameter int INDEX_BITS = 32,
    parameter int PART_BITS  = 16,
    localparam int CFG_BITS  = (INDEX_BITS > PART_BITS) ? INDEX_BITS : PART_BITS,
    localparam int TDATA_BITS = ((INDEX_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rrbig_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_BITS-1:0]                 cfg_data,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rrbig_pkg::IN_TDATA_BITS-1:0] s_axis_tdata,   // [0] restart
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [TDATA_BITS-1:0]               m_axis_tdata,   // sample_index
    output logic                                m_axis_tlast,   // is_last
    output logic [rrbig_pkg::OUT_TUSER_BITS-1:0] m_axis_tuser   // [0] index_valid,
                                                                // [1] bad_partition
);
    import rrbig_pkg::*;

    localparam int GW  = 2 * PART_BITS;
    localparam int OPW = (INDEX_BITS > GW) ? INDEX_BITS : GW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_G     = 4'd2;
    localparam logic [3:0] S_DIV1  = 4'd3;
    localparam logic [3:0] S_DIV2  = 4'd4;
    localparam logic [3:0] S_TMUL1 = 4'd5;
    localparam logic [3:0] S_TMUL2 = 4'd6;
    localparam logic [3:0] S_SFIN  = 4'd7;
    localparam logic [3:0] S_ENTER = 4'd8;
    localparam logic [3:0] S_EMUL1 = 4'd9;
    localparam logic [3:0] S_EMUL2 = 4'd10;
    localparam logic [3:0] S_PROD  = 4'd11;

    // configuration registers
    logic [INDEX_BITS-1:0] ns_reg;
    logic [PART_BITS-1:0]  pid_reg;
    logic [PART_BITS-1:0]  np_reg;
    logic [PART_BITS-1:0]  bs_reg;

    // sequencer and walk state
    logic [3:0]            state_reg, state_next;
    logic                  go_reg, go_next;
    logic                  start_ctx_reg, start_ctx_next;
    logic                  ret_prod_reg, ret_prod_next;
    logic                  restart_reg, restart_next;
    logic [GW-1:0]         g_reg, g_next;
    logic [INDEX_BITS-1:0] full_reg, full_next;
    logic [INDEX_BITS-1:0] rem_reg, rem_next;
    logic                  has_tail_reg, has_tail_next;
    logic [INDEX_BITS-1:0] per_reg, per_next;
    logic [PART_BITS-1:0]  extra_reg, extra_next;
    logic [INDEX_BITS-1:0] tb_reg, tb_next;
    logic [INDEX_BITS-1:0] tl_reg, tl_next;
    logic [INDEX_BITS-1:0] total_reg, total_next;
    logic [INDEX_BITS-1:0] bn_reg, bn_next;
    logic [CFG_BITS-1:0]   pos_reg, pos_next;
    logic [INDEX_BITS-1:0] base_reg, base_next;
    logic [CFG_BITS-1:0]   len_reg, len_next;
    logic                  walk_done_reg, walk_done_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [INDEX_BITS-1:0] m_index_reg, m_index_next;
    logic                  m_ivalid_reg, m_ivalid_next;
    logic                  m_last_reg, m_last_next;
    logic                  m_bad_reg, m_bad_next;

    // shared unit
    alu_ctl_t              alu_ctl;
    alu_sts_t              alu_sts;
    logic [OPW-1:0]        alu_a;
    logic [OPW-1:0]        alu_b;
    logic [OPW-1:0]        alu_quo;
    logic [OPW-1:0]        alu_rem;
    logic                  alu_op;

    logic [PART_BITS-1:0]  beff;
    logic                  bad;
    logic                  out_free;
    logic [INDEX_BITS-1:0] bn_inc;
    logic                  last_batch;
    logic [CFG_BITS-1:0]   pos_inc;
    logic                  pid_lt_extra;
    logic [PART_BITS-1:0]  lead;

    rrbig_alu #(
        .OPW (OPW)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (alu_ctl),
        .opa   (alu_a),
        .opb   (alu_b),
        .sts   (alu_sts),
        .quo   (alu_quo),
        .rem   (alu_rem)
    );

    // Derived values
    assign beff         = (bs_reg == '0) ? PART_BITS'(1) : bs_reg;
    assign bad          = (pid_reg >= np_reg);
    assign out_free     = !m_valid_reg || m_axis_tready;
    assign bn_inc       = bn_reg + INDEX_BITS'(1);
    assign last_batch   = (bn_inc == total_reg);
    assign pos_inc      = pos_reg + CFG_BITS'(1);
    assign pid_lt_extra = (pid_reg < extra_reg);
    assign lead         = pid_lt_extra ? pid_reg : extra_reg;

    // Select operands for the shared unit
    always_comb
    begin
        alu_op = ALU_MUL;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            S_G:
            begin
                alu_a = OPW'(np_reg);
                alu_b = OPW'(beff);
            end
            S_DIV1:
            begin
                alu_op = ALU_DIV;
                alu_a  = OPW'(ns_reg);
                alu_b  = OPW'(g_reg);
            end
            S_DIV2:
            begin
                alu_op = ALU_DIV;
                alu_a  = OPW'(rem_reg);
                alu_b  = OPW'(np_reg);
            end
            S_TMUL1:
            begin
                alu_a = OPW'(g_reg);
                alu_b = OPW'(full_reg);
            end
            S_TMUL2:
            begin
                alu_a = OPW'(per_reg);
                alu_b = OPW'(pid_reg);
            end
            S_EMUL1:
            begin
                alu_a = OPW'(g_reg);
                alu_b = OPW'(bn_reg);
            end
            S_EMUL2:
            begin
                alu_a = OPW'(beff);
                alu_b = OPW'(pid_reg);
            end
            default:
            begin
                alu_op = ALU_MUL;
            end
        endcase
        alu_ctl.op    = alu_op;
        alu_ctl.start = 1'b0;
        if (state_reg == S_G || state_reg == S_DIV1 || state_reg == S_DIV2 ||
            state_reg == S_TMUL1 || state_reg == S_TMUL2 ||
            state_reg == S_EMUL1 || state_reg == S_EMUL2)
        begin
            alu_ctl.start = !go_reg && !alu_sts.busy;
        end
    end

    // Walk sequencer
    always_comb
    begin
        state_next     = state_reg;
        go_next        = go_reg;
        start_ctx_next = start_ctx_reg;
        ret_prod_next  = ret_prod_reg;
        restart_next   = restart_reg;
        g_next         = g_reg;
        full_next      = full_reg;
        rem_next       = rem_reg;
        has_tail_next  = has_tail_reg;
        per_next       = per_reg;
        extra_next     = extra_reg;
        tb_next        = tb_reg;
        tl_next        = tl_reg;
        total_next     = total_reg;
        bn_next        = bn_reg;
        pos_next       = pos_reg;
        base_next      = base_reg;
        len_next       = len_reg;
        walk_done_next = walk_done_reg;

        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_index_next   = m_index_reg;
        m_ivalid_next  = m_ivalid_reg;
        m_last_next    = m_last_reg;
        m_bad_next     = m_bad_reg;

        // Mark an issued operation; clear the mark when it completes
        if (alu_ctl.start)
        begin
            go_next = 1'b1;
        end
        if (alu_sts.done)
        begin
            go_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    restart_next = s_axis_tdata[0];
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (bad)
                begin
                    if (out_free)
                    begin
                        m_valid_next   = 1'b1;
                        m_index_next   = '0;
                        m_ivalid_next  = 1'b0;
                        m_last_next    = 1'b0;
                        m_bad_next     = 1'b1;
                        walk_done_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (restart_reg)
                begin
                    start_ctx_next = 1'b1;
                    state_next     = S_G;
                end
                else
                begin
                    state_next = S_PROD;
                end
            end
            S_G:
            begin
                if (alu_sts.done)
                begin
                    g_next     = alu_quo[GW-1:0];
                    state_next = start_ctx_reg ? S_DIV1 : S_EMUL1;
                end
            end
            S_DIV1:
            begin
                if (alu_sts.done)
                begin
                    full_next = alu_quo[INDEX_BITS-1:0];
                    rem_next  = alu_rem[INDEX_BITS-1:0];
                    if (alu_rem >= OPW'(np_reg))
                    begin
                        has_tail_next = 1'b1;
                        state_next    = S_DIV2;
                    end
                    else
                    begin
                        has_tail_next = 1'b0;
                        tb_next       = '0;
                        tl_next       = '0;
                        state_next    = S_SFIN;
                    end
                end
            end
            S_DIV2:
            begin
                if (alu_sts.done)
                begin
                    per_next   = alu_quo[INDEX_BITS-1:0];
                    extra_next = alu_rem[PART_BITS-1:0];
                    state_next = S_TMUL1;
                end
            end
            S_TMUL1:
            begin
                if (alu_sts.done)
                begin
                    tb_next    = alu_quo[INDEX_BITS-1:0] + INDEX_BITS'(lead);
                    state_next = S_TMUL2;
                end
            end
            S_TMUL2:
            begin
                if (alu_sts.done)
                begin
                    tb_next    = tb_reg + alu_quo[INDEX_BITS-1:0];
                    tl_next    = per_reg + INDEX_BITS'(pid_lt_extra);
                    state_next = S_SFIN;
                end
            end
            S_SFIN:
            begin
                total_next     = full_reg + INDEX_BITS'(has_tail_reg);
                bn_next        = '0;
                pos_next       = '0;
                start_ctx_next = 1'b0;
                if (full_reg == '0 && !has_tail_reg)
                begin
                    walk_done_next = 1'b1;
                    state_next     = S_PROD;
                end
                else
                begin
                    walk_done_next = 1'b0;
                    ret_prod_next  = 1'b1;
                    state_next     = S_ENTER;
                end
            end
            S_ENTER:
            begin
                if (has_tail_reg && last_batch)
                begin
                    base_next  = tb_reg;
                    len_next   = CFG_BITS'(tl_reg);
                    pos_next   = '0;
                    state_next = ret_prod_reg ? S_PROD : S_IDLE;
                end
                else
                begin
                    state_next = S_G;
                end
            end
            S_EMUL1:
            begin
                if (alu_sts.done)
                begin
                    base_next  = alu_quo[INDEX_BITS-1:0];
                    state_next = S_EMUL2;
                end
            end
            S_EMUL2:
            begin
                if (alu_sts.done)
                begin
                    base_next  = base_reg + alu_quo[INDEX_BITS-1:0];
                    len_next   = CFG_BITS'(beff);
                    pos_next   = '0;
                    state_next = ret_prod_reg ? S_PROD : S_IDLE;
                end
            end
            S_PROD:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_bad_next   = 1'b0;
                    if (walk_done_reg)
                    begin
                        m_index_next  = '0;
                        m_ivalid_next = 1'b0;
                        m_last_next   = 1'b0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        m_index_next  = base_reg + INDEX_BITS'(pos_reg);
                        m_ivalid_next = 1'b1;
                        m_last_next   = last_batch && (pos_inc == len_reg);
                        pos_next      = pos_inc;
                        state_next    = S_IDLE;
                        // Advance to the next batch at the end of this one
                        if (pos_inc == len_reg)
                        begin
                            bn_next = bn_inc;
                            if (last_batch)
                            begin
                                walk_done_next = 1'b1;
                            end
                            else
                            begin
                                ret_prod_next = 1'b0;
                                state_next    = S_ENTER;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_reg  <= '0;
            pid_reg <= '0;
            np_reg  <= PART_BITS'(1);
            bs_reg  <= PART_BITS'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NUM_SAMPLES:    ns_reg  <= INDEX_BITS'(cfg_data);
                CFG_PARTITION_ID:   pid_reg <= PART_BITS'(cfg_data);
                CFG_NUM_PARTITIONS: np_reg  <= PART_BITS'(cfg_data);
                CFG_BATCH_SIZE:     bs_reg  <= PART_BITS'(cfg_data);
                default:            ns_reg  <= ns_reg;
            endcase
        end
    end

    // Sequencer, walk and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            go_reg        <= 1'b0;
            start_ctx_reg <= 1'b0;
            ret_prod_reg  <= 1'b0;
            restart_reg   <= 1'b0;
            g_reg         <= '0;
            full_reg      <= '0;
            rem_reg       <= '0;
            has_tail_reg  <= 1'b0;
            per_reg       <= '0;
            extra_reg     <= '0;
            tb_reg        <= '0;
            tl_reg        <= '0;
            total_reg     <= '0;
            bn_reg        <= '0;
            pos_reg       <= '0;
            base_reg      <= '0;
            len_reg       <= '0;
            walk_done_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
            m_index_reg   <= '0;
            m_ivalid_reg  <= 1'b0;
            m_last_reg    <= 1'b0;
            m_bad_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            start_ctx_reg <= start_ctx_next;
            ret_prod_reg  <= ret_prod_next;
            restart_reg   <= restart_next;
            g_reg         <= g_next;
            full_reg      <= full_next;
            rem_reg       <= rem_next;
            has_tail_reg  <= has_tail_next;
            per_reg       <= per_next;
            extra_reg     <= extra_next;
            tb_reg        <= tb_next;
            tl_reg        <= tl_next;
            total_reg     <= total_next;
            bn_reg        <= bn_next;
            pos_reg       <= pos_next;
            base_reg      <= base_next;
            len_reg       <= len_next;
            walk_done_reg <= walk_done_next;
            m_valid_reg   <= m_valid_next;
            m_index_reg   <= m_index_next;
            m_ivalid_reg  <= m_ivalid_next;
            m_last_reg    <= m_last_next;
            m_bad_reg     <= m_bad_next;
        end
    end

    // Ports
    assign cfg_ready                = 1'b1;
    assign s_axis_tready            = (state_reg == S_IDLE);
    assign m_axis_tvalid            = m_valid_reg;
    assign m_axis_tdata             = TDATA_BITS'(m_index_reg);
    assign m_axis_tlast             = m_last_reg;
    assign m_axis_tuser[TUSER_VALID] = m_ivalid_reg;
    assign m_axis_tuser[TUSER_BAD]   = m_bad_reg;

endmodule

/* tb/rrbig_index_checker.sv */
// Checker: predicts the index walk from observed traffic and compares every result item.
module rrbig_index_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [rrbig_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [31:0]                          cfg_data,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [rrbig_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [31:0]                          m_axis_tdata,
    input  logic                                 m_axis_tlast,
    input  logic [rrbig_pkg::OUT_TUSER_BITS-1:0] m_axis_tuser,
    output int                                   fail_count,
    output int                                   outstanding
);
    import rrbig_pkg::*;

    localparam int IDX_W = 32;
    localparam int PRT_W = 16;
    localparam longint unsigned IDX_MASK = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [IDX_W-1:0] sample_index;
        logic             index_valid;
        logic             is_last;
        logic             bad_partition;
    } index_item_t;

    // Shadow copy of the configuration registers
    logic [IDX_W-1:0] num_samples_r;
    logic [PRT_W-1:0] part_id_r;
    logic [PRT_W-1:0] part_cnt_r;
    logic [PRT_W-1:0] batch_len_r;

    // Walk position
    longint unsigned batch_no;
    longint unsigned batch_total;
    bit              tail_present;
    longint unsigned pos;
    longint unsigned seg_base;
    longint unsigned seg_len;
    longint unsigned tail_start;
    longint unsigned tail_len;
    bit              walk_over;

    index_item_t indices_due[$];
    int          errors;

    // Batch size of zero behaves as one
    function automatic longint unsigned eff_len();
        return (batch_len_r == '0) ? 64'd1 : 64'(batch_len_r);
    endfunction

    // Load base and length of the batch the walk has just entered
    function automatic void enter_segment();
        longint unsigned b;
        b = eff_len();
        if (tail_present && batch_no == batch_total - 64'd1)
        begin
            seg_base = tail_start;
            seg_len  = tail_len;
        end
        else
        begin
            seg_base = (batch_no * (64'(part_cnt_r) * b) + b * 64'(part_id_r)) & IDX_MASK;
            seg_len  = b;
        end
        pos = '0;
    endfunction

    // Advance the walk by one request and return the result it produces
    function automatic index_item_t next_index(input logic restart_walk);
        index_item_t     r;
        longint unsigned b, g, full, rem, per, extra, lead;
        r = '0;
        if (part_id_r >= part_cnt_r)
        begin
            walk_over       = 1'b1;
            r.bad_partition = 1'b1;
            return r;
        end
        if (restart_walk)
        begin
            b            = eff_len();
            g            = 64'(part_cnt_r) * b;
            full         = 64'(num_samples_r) / g;
            rem          = 64'(num_samples_r) % g;
            tail_present = (rem >= 64'(part_cnt_r));
            batch_total  = full + (tail_present ? 64'd1 : 64'd0);
            tail_start   = '0;
            tail_len     = '0;
            if (tail_present)
            begin
                per        = rem / 64'(part_cnt_r);
                extra      = rem % 64'(part_cnt_r);
                lead       = (64'(part_id_r) < extra) ? 64'(part_id_r) : extra;
                tail_start = (full * g + per * 64'(part_id_r) + lead) & IDX_MASK;
                tail_len   = per + ((64'(part_id_r) < extra) ? 64'd1 : 64'd0);
            end
            batch_no  = '0;
            walk_over = (batch_total == '0);
            if (!walk_over)
                enter_segment();
            else
                pos = '0;
        end
        if (walk_over)
            return r;
        r.sample_index = IDX_W'((seg_base + pos) & IDX_MASK);
        r.index_valid  = 1'b1;
        r.is_last      = (batch_no == batch_total - 64'd1) && (pos + 64'd1 == seg_len);
        pos++;
        if (pos >= seg_len)
        begin
            batch_no++;
            if (batch_no >= batch_total)
                walk_over = 1'b1;
            else
                enter_segment();
        end
        return r;
    endfunction

    task automatic flag_field(input string field, input longint unsigned want,
                              input longint unsigned got);
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    endtask

    // Track configuration, queue predictions, check results
    always @(posedge clk or negedge rst_n)
    begin
        index_item_t want;
        index_item_t got;
        if (!rst_n)
        begin
            indices_due.delete();
            errors        = 0;
            num_samples_r = '0;
            part_id_r     = '0;
            part_cnt_r    = PRT_W'(1);
            batch_len_r   = PRT_W'(1);
            batch_no      = '0;
            batch_total   = '0;
            tail_present  = 1'b0;
            pos           = '0;
            seg_base      = '0;
            seg_len       = '0;
            tail_start    = '0;
            tail_len      = '0;
            walk_over     = 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NUM_SAMPLES:    num_samples_r = cfg_data[IDX_W-1:0];
                    CFG_PARTITION_ID:   part_id_r     = cfg_data[PRT_W-1:0];
                    CFG_NUM_PARTITIONS: part_cnt_r    = cfg_data[PRT_W-1:0];
                    CFG_BATCH_SIZE:     batch_len_r   = cfg_data[PRT_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                indices_due.push_back(next_index(s_axis_tdata[0]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.sample_index  = m_axis_tdata[IDX_W-1:0];
                got.index_valid   = m_axis_tuser[TUSER_VALID];
                got.is_last       = m_axis_tlast;
                got.bad_partition = m_axis_tuser[TUSER_BAD];
                if (indices_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result item with none expected, %s %0h %s %0b %s %0b %s %0b",
                             $time, "actual index", got.sample_index,
                             "valid", got.index_valid, "last", got.is_last,
                             "bad", got.bad_partition);
                end
                else
                begin
                    want = indices_due.pop_front();
                    if (got.sample_index !== want.sample_index)
                        flag_field("sample_index", 64'(want.sample_index),
                                   64'(got.sample_index));
                    if (got.index_valid !== want.index_valid)
                        flag_field("index_valid", 64'(want.index_valid),
                                   64'(got.index_valid));
                    if (got.is_last !== want.is_last)
                        flag_field("is_last", 64'(want.is_last), 64'(got.is_last));
                    if (got.bad_partition !== want.bad_partition)
                        flag_field("bad_partition", 64'(want.bad_partition),
                                   64'(got.bad_partition));
                end
            end
        end
        fail_count  <= errors;
        outstanding <= indices_due.size();
    end

endmodule

/* tb/tb_round_robin_batch_index_generator_core.sv */
// Testbench top: drives configuration and request items, throttles results, gives the verdict.
module tb_round_robin_batch_index_generator_core;
    import rrbig_pkg::*;

    // Longest busy stretch after a result is a batch entry of three serial operations
    localparam int SETTLE_CYCLES = 128;
    localparam int STALL_LIMIT   = 5000;
    localparam int ITEM_TARGET   = 1550;

    // Configuration write masks, one bit per register
    localparam logic [3:0] WR_SAMPLES = 4'b0001;
    localparam logic [3:0] WR_PART    = 4'b0010;
    localparam logic [3:0] WR_COUNT   = 4'b0100;
    localparam logic [3:0] WR_BATCH   = 4'b1000;
    localparam logic [3:0] WR_ALL     = 4'b1111;

    typedef enum int {RX_OPEN, RX_CHOPPY, RX_STALLS} rx_mode_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index     = '0;
    logic [31:0]               cfg_data      = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [31:0]               m_axis_tdata;
    logic                      m_axis_tlast;
    logic [OUT_TUSER_BITS-1:0] m_axis_tuser;

    int       fail_count;
    int       outstanding;
    int       items_sent    = 0;
    int       burst_left    = 0;
    int       idle_cycles   = 0;
    rx_mode_t rx_mode       = RX_OPEN;
    int       rx_mode_left  = 0;
    int       rx_hold       = 0;

    round_robin_batch_index_generator_core u_top (.*);

    rrbig_index_checker u_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: switch between open, choppy and long-stall patterns
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(50, 400);
        end
        else
            rx_mode_left--;
        case (rx_mode)
            RX_OPEN:   m_axis_tready = 1'b1;
            RX_CHOPPY: m_axis_tready = ($urandom_range(0, 3) != 0);
            default:
                if (rx_hold == 0)
                begin
                    m_axis_tready = !m_axis_tready;
                    rx_hold = m_axis_tready ? $urandom_range(0, 3) : $urandom_range(1, 20);
                end
                else
                    rx_hold--;
        endcase
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("round_robin_batch_index_generator_core verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Send one request item, opening a new burst after a random gap when due
    task automatic send_request(input logic restart_walk);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 8);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(IN_TDATA_BITS-1){1'b0}}, restart_walk};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    // Hold off until every result is back and the sequencer has gone quiet
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Write the registers selected by the mask once the block is idle
    task automatic configure(input logic [3:0] mask, input logic [31:0] ns,
                             input logic [31:0] pid, input logic [31:0] np,
                             input logic [31:0] bs);
        settle();
        if (mask & WR_SAMPLES) write_reg(CFG_NUM_SAMPLES, ns);
        if (mask & WR_PART)    write_reg(CFG_PARTITION_ID, pid);
        if (mask & WR_COUNT)   write_reg(CFG_NUM_PARTITIONS, np);
        if (mask & WR_BATCH)   write_reg(CFG_BATCH_SIZE, bs);
        cfg_valid = 1'b0;
    endtask

    // Put random junk above a 16-bit register value now and then
    function automatic logic [31:0] with_noise(input logic [15:0] v);
        return {(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0), v};
    endfunction

    initial
    begin
        int   np, pid, bs, count;
        logic [31:0] ns;
        logic [3:0]  mask;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Exhausted walk straight out of reset, then an empty walk
        send_request(1'b0);
        send_request(1'b1);

        // Full batch plus a tail with one extra sample for the leading partitions
        configure(WR_ALL, 10, 2, 3, 2);
        send_request(1'b1);
        repeat (3) send_request(1'b0);

        // Partition id equal to the partition count
        configure(WR_PART, 0, 3, 0, 0);
        send_request(1'b1);
        send_request(1'b0);

        // No partitions at all
        configure(WR_PART | WR_COUNT, 0, 0, 0, 0);
        send_request(1'b1);

        // Zero batch size acts as one
        configure(WR_ALL, 3, 0, 1, 0);
        send_request(1'b1);
        repeat (3) send_request(1'b0);

        // Largest sizes everywhere
        configure(WR_ALL, 32'hFFFF_FFFF, 32'h0000_FFFE, 32'h0000_FFFF, 32'h0000_FFFF);
        send_request(1'b1);
        repeat (2) send_request(1'b0);

        // Largest partition id is always out of range
        configure(WR_PART, 0, 32'h0000_FFFF, 0, 0);
        send_request(1'b0);

        // Registers changed mid-walk feed the next batch base
        configure(WR_ALL, 32'hFFFF_FFFF, 0, 1, 1);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        configure(WR_COUNT, 0, 0, 32'h0000_FFFF, 0);
        repeat (2) send_request(1'b0);

        // Random phases: mostly small walks started by a restart and run out
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                np    = $urandom_range(0, 65535);
                pid   = (np == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                               : $urandom_range(0, np - 1);
                bs    = $urandom_range(0, 65535);
                ns    = $urandom;
                count = $urandom_range(1, 6);
            end
            else
            begin
                np = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
                if (np == 0)
                    pid = $urandom_range(0, 2);
                else if ($urandom_range(0, 9) == 0)
                    pid = $urandom_range(np, np + 2);
                else
                    pid = $urandom_range(0, np - 1);
                bs    = $urandom_range(0, 5);
                ns    = $urandom_range(0, 48);
                count = $urandom_range(1, 40);
            end
            mask = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : WR_ALL;
            configure(mask, ns, with_noise(16'(pid)), with_noise(16'(np)),
                      with_noise(16'(bs)));
            for (int k = 0; k < count; k++)
                send_request((k == 0) ? ($urandom_range(0, 7) != 0)
                                      : ($urandom_range(0, 23) == 0));
        end

        settle();
        if (fail_count == 0 && outstanding == 0)
            $display("round_robin_batch_index_generator_core verification clean");
        else
            $display("round_robin_batch_index_generator_core verification failed");
        $finish;
    end

endmodule
